### src/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg: shared definitions for the line follower PD drive unit
// Field widths, register indexes, reset values and datapath sizes.
// ----------------------------------------------------------------------------
package lfpd_pkg;

   localparam int COUNT_BITS  = 24;
   localparam int SAMPLE_BITS = 10;

   localparam int GAIN_W     = 10;
   localparam int THR_W      = 10;
   localparam int SPACE_W    = 8;
   localparam int DUTY_W     = 16;
   localparam int OUT_DUTY_W = 17;
   localparam int ERR_W      = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // run length sum and shared multiplier operands
   localparam int N_W    = COUNT_BITS + 1;
   localparam int MA_W   = 22;
   localparam int MB_W   = (N_W + 1 > 12) ? N_W + 1 : 12;
   localparam int PROD_W = MA_W + MB_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int DCNT_W = $clog2(NUM_W + 1);
   localparam int G_W    = 32;
   localparam int MIX_W  = 36;

   localparam int DUTY_LIMIT   = 65535;
   localparam int SLOPE_FACTOR = 2000;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_ON_TAPE_THR  = 3'd0;
   localparam csr_index_type CSR_FOIL_THR     = 3'd1;
   localparam csr_index_type CSR_SPACING      = 3'd2;
   localparam csr_index_type CSR_LEFT_NOM     = 3'd3;
   localparam csr_index_type CSR_RIGHT_NOM    = 3'd4;
   localparam csr_index_type CSR_REV_EXTRA    = 3'd5;

   localparam logic [THR_W-1:0]   ON_TAPE_THR_RST = 10'd200;
   localparam logic [THR_W-1:0]   FOIL_THR_RST    = 10'd40;
   localparam logic [SPACE_W-1:0] SPACING_RST     = 8'd10;
   localparam logic [DUTY_W-1:0]  LEFT_NOM_RST    = 16'd31000;
   localparam logic [DUTY_W-1:0]  RIGHT_NOM_RST   = 16'd33000;
   localparam logic [DUTY_W-1:0]  REV_EXTRA_RST   = 16'd2000;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [N_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

### src/lfpd_req_if.sv
// ----------------------------------------------------------------------------
// lfpd_req_if: request channel of the line follower PD drive unit
// Valid/ready handshake carrying two sensor samples and two gain settings.
// ----------------------------------------------------------------------------
interface lfpd_req_if;
   import lfpd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] left_sample;
   logic [SAMPLE_BITS-1:0] right_sample;
   logic [GAIN_W-1:0]      prop_gain_raw;
   logic [GAIN_W-1:0]      deriv_gain_raw;

   modport source (
      output valid, left_sample, right_sample, prop_gain_raw, deriv_gain_raw,
      input  ready
   );

   modport sink (
      input  valid, left_sample, right_sample, prop_gain_raw, deriv_gain_raw,
      output ready
   );
endinterface

### src/lfpd_rsp_if.sv
// ----------------------------------------------------------------------------
// lfpd_rsp_if: response channel of the line follower PD drive unit
// Valid/ready handshake carrying signed motor duties and status.
// ----------------------------------------------------------------------------
interface lfpd_rsp_if;
   import lfpd_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [OUT_DUTY_W-1:0] left_duty;
   logic signed [OUT_DUTY_W-1:0] right_duty;
   logic                         reversing;
   logic signed [ERR_W-1:0]      line_error;

   modport source (
      output valid, left_duty, right_duty, reversing, line_error,
      input  ready
   );

   modport sink (
      input  valid, left_duty, right_duty, reversing, line_error,
      output ready
   );
endinterface

### src/lfpd_div.sv
// ----------------------------------------------------------------------------
// lfpd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfpd_div (
   input  logic                 clock,
   input  logic                 reset,
   input  lfpd_pkg::div_req_type div_req,
   output lfpd_pkg::div_rsp_type div_rsp
);
   import lfpd_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [N_W-1:0]    rem_ff;
   logic [N_W-1:0]    rem_in;
   logic [N_W-1:0]    divisor_ff;
   logic [NUM_W-1:0]  quo_ff;
   logic [NUM_W-1:0]  quo_in;
   logic [N_W:0]      trial;
   logic [N_W:0]      trial_diff;
   logic              fits;

   always_comb begin
      trial      = {rem_ff, quo_ff[NUM_W-1]};
      trial_diff = trial - {1'b0, divisor_ff};
      fits       = trial >= {1'b0, divisor_ff};
      rem_in     = fits ? trial_diff[N_W-1:0] : trial[N_W-1:0];
      quo_in     = {quo_ff[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (div_req.start) begin
            busy_ff    <= 1'b1;
            done_ff    <= 1'b0;
            cnt_ff     <= '0;
            rem_ff     <= '0;
            quo_ff     <= div_req.dividend;
            divisor_ff <= div_req.divisor;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quo_ff  <= quo_in;
            cnt_ff  <= cnt_ff + 1'b1;
            done_ff <= (cnt_ff == DCNT_W'(NUM_W - 1));
            if (cnt_ff == DCNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### src/line_follow_pd_drive_unit.sv
// ----------------------------------------------------------------------------
// line_follow_pd_drive_unit: two-sensor PD tape follower with motor duties
// Classifies the sensors, tracks error runs, forms the PD correction with a
// shared multiplier and an iterative divider, and mixes it into the duties.
// ----------------------------------------------------------------------------
// req_chan carries left/right sensor samples and the P and D gain settings;
// rsp_chan returns signed left/right duties, a reversing flag and the line
// error used, one response per request, in order. The csr_* port writes the
// six tuning registers; write them only while no request is in flight.
// One request at a time: req_chan.ready stays low from accept until the
// response is loaded into the output register. Steps: on foil, classify and
// mix; without a derivative term yet, classify, P and run length multiplies,
// mix; with it, classify, P, run length, D and slope multiplies, add, sign,
// the one-bit-per-cycle restoring divider and mix.
// Reset is synchronous, active high: registers return to defaults, the error
// history clears, the run count restarts at one and both channels go idle.
// A stalled response waits in the output register; the next request is still
// accepted and worked, then holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module line_follow_pd_drive_unit (
   input  logic                               clock,
   input  logic                               reset,
   lfpd_req_if.sink                           req_chan,
   lfpd_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  lfpd_pkg::csr_index_type            csr_index,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lfpd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_MUL_P,
      ST_MUL_PN,
      ST_MUL_D,
      ST_MUL_DS,
      ST_ADD,
      ST_SIGN,
      ST_DIV,
      ST_MIX
   } state_type;

   localparam logic signed [MB_W-1:0] SLOPE_OPERAND = MB_W'(SLOPE_FACTOR);

   state_type state_ff;

   // tuning registers
   logic [THR_W-1:0]   on_tape_ff;
   logic [THR_W-1:0]   foil_thr_ff;
   logic [SPACE_W-1:0] spacing_ff;
   logic [DUTY_W-1:0]  left_nom_ff;
   logic [DUTY_W-1:0]  right_nom_ff;
   logic [DUTY_W-1:0]  rev_extra_ff;

   // error history
   logic signed [ERR_W-1:0] last_err_ff;
   logic                    last_valid_ff;
   logic [COUNT_BITS-1:0]   run_ff;
   logic [COUNT_BITS-1:0]   prior_cnt_ff;
   logic                    prior_valid_ff;
   logic signed [ERR_W-1:0] prior_err_ff;

   // request capture and work registers
   logic [SAMPLE_BITS-1:0]  ls_ff;
   logic [SAMPLE_BITS-1:0]  rs_ff;
   logic [GAIN_W-1:0]       pgain_ff;
   logic [GAIN_W-1:0]       dgain_ff;
   logic                    foil_ff;
   logic                    deriv_ff;
   logic signed [ERR_W-1:0] e_ff;
   logic signed [ERR_W:0]   de_ff;
   logic [N_W-1:0]          n_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic                    neg_ff;
   logic signed [G_W-1:0]   g_ff;

   // response register
   logic                         rsp_valid_ff;
   logic signed [OUT_DUTY_W-1:0] rsp_left_ff;
   logic signed [OUT_DUTY_W-1:0] rsp_right_ff;
   logic                         rsp_rev_ff;
   logic signed [ERR_W-1:0]      rsp_err_ff;

   logic req_accept;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // ---------------------------------------------------------------- classify
   logic                    is_foil;
   logic                    left_on;
   logic                    right_on;
   logic signed [ERR_W-1:0] s_pos;
   logic signed [ERR_W-1:0] e_calc;
   logic [COUNT_BITS-1:0]   run_in;
   logic [COUNT_BITS-1:0]   prior_cnt_in;
   logic signed [ERR_W-1:0] prior_err_in;
   logic                    prior_valid_in;
   logic [N_W-1:0]          n_in;
   logic signed [ERR_W:0]   de_in;

   always_comb begin
      is_foil  = (ls_ff < foil_thr_ff) && (rs_ff < foil_thr_ff);
      left_on  = ls_ff > on_tape_ff;
      right_on = rs_ff > on_tape_ff;
      s_pos    = $signed({1'b0, spacing_ff});

      priority if (left_on && right_on) begin
         e_calc = '0;
      end else if (right_on) begin
         e_calc = -9'sd1;
      end else if (left_on) begin
         e_calc = 9'sd1;
      end else if (last_valid_ff && (last_err_ff > 9'sd0)) begin
         e_calc = s_pos;
      end else begin
         e_calc = -s_pos;
      end

      run_in         = run_ff;
      prior_cnt_in   = prior_cnt_ff;
      prior_err_in   = prior_err_ff;
      prior_valid_in = prior_valid_ff;
      if (last_valid_ff) begin
         if (last_err_ff == e_calc) begin
            if (run_ff != '1) begin
               run_in = run_ff + 1'b1;
            end
         end else begin
            // close the old run
            prior_cnt_in   = run_ff;
            prior_err_in   = last_err_ff;
            run_in         = COUNT_BITS'(1);
            prior_valid_in = 1'b1;
         end
      end

      n_in  = {1'b0, prior_cnt_in} + {1'b0, run_in} - N_W'(1);
      de_in = {e_calc[ERR_W-1], e_calc} - {prior_err_in[ERR_W-1], prior_err_in};
   end

   // ------------------------------------------------------- shared multiplier
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      unique case (state_ff)
         ST_MUL_P: begin
            mul_a = {{(MA_W-ERR_W){e_ff[ERR_W-1]}}, e_ff};
            mul_b = {{(MB_W-GAIN_W-1){1'b0}}, pgain_ff, 1'b0};
         end
         ST_MUL_PN: begin
            mul_a = prod_ff[MA_W-1:0];
            mul_b = {{(MB_W-N_W){1'b0}}, n_ff};
         end
         ST_MUL_D: begin
            mul_a = {{(MA_W-ERR_W-1){de_ff[ERR_W]}}, de_ff};
            mul_b = {{(MB_W-GAIN_W-1){1'b0}}, dgain_ff, 1'b0};
         end
         ST_MUL_DS: begin
            mul_a = prod_ff[MA_W-1:0];
            mul_b = SLOPE_OPERAND;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // ----------------------------------------------------------------- divider
   div_req_type             div_req;
   div_rsp_type             div_rsp;
   logic signed [G_W-1:0]   quo_s;

   assign div_req.start    = (state_ff == ST_SIGN);
   assign div_req.dividend = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign div_req.divisor  = n_ff;
   assign quo_s            = $signed(div_rsp.quotient[G_W-1:0]);

   lfpd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ------------------------------------------------------------------ mixing
   function automatic logic signed [OUT_DUTY_W-1:0] sat_duty(
      input logic signed [MIX_W-1:0] v
   );
      logic signed [MIX_W-1:0] lim;
      lim = MIX_W'(DUTY_LIMIT);
      if (v > lim) begin
         return OUT_DUTY_W'(lim);
      end else if (v < -lim) begin
         return OUT_DUTY_W'(-lim);
      end
      return v[OUT_DUTY_W-1:0];
   endfunction

   logic signed [MIX_W-1:0] g_x;
   logic signed [MIX_W-1:0] m_x;
   logic signed [MIX_W-1:0] ln_x;
   logic signed [MIX_W-1:0] rn_x;
   logic signed [MIX_W-1:0] ext_x;
   logic signed [MIX_W-1:0] v_x;
   logic signed [MIX_W-1:0] l_x;
   logic signed [MIX_W-1:0] r_x;
   logic                    g_pos;
   logic                    g_neg;
   logic                    spacing_hit;

   always_comb begin
      g_x   = {{(MIX_W-G_W){g_ff[G_W-1]}}, g_ff};
      g_neg = g_ff[G_W-1];
      g_pos = !g_neg && (g_ff != '0);
      m_x   = g_neg ? -g_x : g_x;
      ln_x  = $signed({{(MIX_W-DUTY_W){1'b0}}, left_nom_ff});
      rn_x  = $signed({{(MIX_W-DUTY_W){1'b0}}, right_nom_ff});
      ext_x = $signed({{(MIX_W-DUTY_W){1'b0}}, rev_extra_ff});
      v_x   = (ln_x <<< 1) - g_x - (g_x <<< 1);
      spacing_hit = (e_ff == s_pos) || (e_ff == -s_pos);

      priority if (foil_ff) begin
         l_x = -(ln_x + ext_x);
         r_x = -rn_x;
      end else if (g_pos && spacing_hit) begin
         // halve toward zero
         l_x = (v_x >>> 1) + ((v_x[MIX_W-1] && v_x[0]) ? MIX_W'(1) : MIX_W'(0));
         r_x = rn_x + g_x;
      end else if (g_neg && spacing_hit) begin
         l_x = ln_x + m_x;
         r_x = rn_x - ((m_x + (m_x <<< 1)) >>> 2);
      end else if (g_pos) begin
         l_x = ln_x - (g_x >>> 1);
         r_x = rn_x + g_x;
      end else if (g_neg) begin
         l_x = ln_x + m_x;
         r_x = rn_x - (m_x >>> 1);
      end else begin
         l_x = ln_x;
         r_x = rn_x;
      end
   end

   // --------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         on_tape_ff     <= ON_TAPE_THR_RST;
         foil_thr_ff    <= FOIL_THR_RST;
         spacing_ff     <= SPACING_RST;
         left_nom_ff    <= LEFT_NOM_RST;
         right_nom_ff   <= RIGHT_NOM_RST;
         rev_extra_ff   <= REV_EXTRA_RST;
         last_err_ff    <= '0;
         last_valid_ff  <= 1'b0;
         run_ff         <= COUNT_BITS'(1);
         prior_cnt_ff   <= '0;
         prior_valid_ff <= 1'b0;
         prior_err_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ON_TAPE_THR: on_tape_ff   <= csr_wdata[THR_W-1:0];
               CSR_FOIL_THR:    foil_thr_ff  <= csr_wdata[THR_W-1:0];
               CSR_SPACING:     spacing_ff   <= csr_wdata[SPACE_W-1:0];
               CSR_LEFT_NOM:    left_nom_ff  <= csr_wdata[DUTY_W-1:0];
               CSR_RIGHT_NOM:   right_nom_ff <= csr_wdata[DUTY_W-1:0];
               CSR_REV_EXTRA:   rev_extra_ff <= csr_wdata[DUTY_W-1:0];
               default: ;
            endcase
         end

         // ST_MIX reloads the register itself when it is taken
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_MIX)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  ls_ff    <= req_chan.left_sample;
                  rs_ff    <= req_chan.right_sample;
                  pgain_ff <= req_chan.prop_gain_raw;
                  dgain_ff <= req_chan.deriv_gain_raw;
                  state_ff <= ST_CLASSIFY;
               end
            end
            ST_CLASSIFY: begin
               if (is_foil) begin
                  // reverse drive, history untouched
                  foil_ff  <= 1'b1;
                  e_ff     <= '0;
                  state_ff <= ST_MIX;
               end else begin
                  foil_ff        <= 1'b0;
                  e_ff           <= e_calc;
                  de_ff          <= de_in;
                  n_ff           <= n_in;
                  deriv_ff       <= prior_valid_in;
                  last_err_ff    <= e_calc;
                  last_valid_ff  <= 1'b1;
                  run_ff         <= run_in;
                  prior_cnt_ff   <= prior_cnt_in;
                  prior_err_ff   <= prior_err_in;
                  prior_valid_ff <= prior_valid_in;
                  state_ff       <= ST_MUL_P;
               end
            end
            ST_MUL_P: begin
               prod_ff  <= prod_in;
               state_ff <= ST_MUL_PN;
            end
            ST_MUL_PN: begin
               if (deriv_ff) begin
                  prod_ff  <= prod_in;
                  state_ff <= ST_MUL_D;
               end else begin
                  g_ff     <= {prod_ff[G_W-2:0], 1'b0};
                  state_ff <= ST_MIX;
               end
            end
            ST_MUL_D: begin
               num_ff   <= {prod_ff, 1'b0};
               prod_ff  <= prod_in;
               state_ff <= ST_MUL_DS;
            end
            ST_MUL_DS: begin
               prod_ff  <= prod_in;
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               num_ff   <= num_ff + {prod_ff[PROD_W-1], prod_ff};
               state_ff <= ST_SIGN;
            end
            ST_SIGN: begin
               neg_ff   <= num_ff[NUM_W-1];
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  g_ff     <= neg_ff ? -quo_s : quo_s;
                  state_ff <= ST_MIX;
               end
            end
            ST_MIX: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_left_ff  <= sat_duty(l_x);
                  rsp_right_ff <= sat_duty(r_x);
                  rsp_rev_ff   <= foil_ff;
                  rsp_err_ff   <= e_ff;
                  state_ff     <= ST_IDLE;
               end else begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.left_duty  = rsp_left_ff;
   assign rsp_chan.right_duty = rsp_right_ff;
   assign rsp_chan.reversing  = rsp_rev_ff;
   assign rsp_chan.line_error = rsp_err_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_chan.ready)
      else $error("request accepted while a request is in flight");

   a_reverse_zero_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.reversing) |-> (rsp_chan.line_error == '0))
      else $error("reverse response carries a nonzero line error");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (run_ff != '0) && (!prior_valid_ff || (prior_cnt_ff != '0)))
      else $error("run count lost its minimum of one");

   a_div_needs_deriv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> deriv_ff)
      else $error("divider used without a derivative term");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((rsp_chan.left_duty != $signed(17'h10000)) &&
                          (rsp_chan.right_duty != $signed(17'h10000))))
      else $error("duty outside the saturation range");
`endif

endmodule
